@@ rtl/mad_pkg.sv @@
// ----------------------------------------------------------------------------
// mad_pkg
// Shared types and constants of the moving average anomaly detector.
// ----------------------------------------------------------------------------
package mad_pkg;

  localparam int SAMPLE_W = 16;
  localparam int THR_W    = 16;

  localparam logic [THR_W-1:0] THR_RESET = 16'd5120;  // 20.0 in q8.8

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [THR_W-1:0]    thr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_START,
    S_DIV,
    S_FIN
  } mad_state_t;

endpackage

@@ rtl/mad_in_if.sv @@
// ----------------------------------------------------------------------------
// mad_in_if
// Sample channel: valid/ready handshake carrying one q8.8 sample per item.
// ----------------------------------------------------------------------------
interface mad_in_if;
  import mad_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);

endinterface

@@ rtl/mad_out_if.sv @@
// ----------------------------------------------------------------------------
// mad_out_if
// Result channel: valid/ready handshake carrying the mean and anomaly flag.
// ----------------------------------------------------------------------------
interface mad_out_if;
  import mad_pkg::*;

  logic    valid;
  logic    ready;
  sample_t mean;
  logic    anomaly;

  modport source (output valid, output mean, output anomaly, input ready);
  modport sink   (input valid, input mean, input anomaly, output ready);

endinterface

@@ rtl/mad_ram.sv @@
// ----------------------------------------------------------------------------
// mad_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module mad_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 20,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/mad_div.sv @@
// ----------------------------------------------------------------------------
// mad_div
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module mad_div #(
  parameter int SUM_W = 21,
  parameter int CNT_W = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [SUM_W-1:0]  dividend,
  input  logic        [CNT_W-1:0]  divisor,
  output logic                     done,
  output mad_pkg::sample_t         quotient
);
  import mad_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic              neg_r;
  logic [CNT_W-1:0]  divisor_r;
  logic [CNT_W-1:0]  rem_r;
  logic [SUM_W-1:0]  quo_r;
  sample_t           quotient_r;

  logic [SUM_W-1:0]  mag;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    diff;
  logic              ge;
  logic [SAMPLE_W-1:0] quo_lo;

  assign mag    = dividend[SUM_W-1] ? (~$unsigned(dividend) + 1'b1) : $unsigned(dividend);
  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, divisor_r};
  assign diff   = rem_sh - {1'b0, divisor_r};
  assign quo_lo = quo_r[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && !start && (step_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W);
      end else if (busy_r) begin
        if (step_r != '0) begin
          step_r <= step_r - 1'b1;
        end else begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r     <= dividend[SUM_W-1];
      divisor_r <= divisor;
      rem_r     <= '0;
      quo_r     <= mag;
    end else if (busy_r) begin
      if (step_r != '0) begin
        rem_r <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], ge};
      end else begin
        // sign fix-up; the mean always fits in the sample width
        quotient_r <= neg_r ? sample_t'(-quo_lo) : sample_t'(quo_lo);
      end
    end
  end

  assign done     = done_r;
  assign quotient = quotient_r;

endmodule

@@ rtl/moving_average_anomaly_detector_unit.sv @@
// ----------------------------------------------------------------------------
// moving_average_anomaly_detector_unit
// Moving average over the last WINDOW q8.8 samples with a threshold check.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A sample is taken when in_if.ready is
// high; the oldest window entry is read from the sample ram, the running sum
// is updated and the new sample written back, then the sum is divided by
// the fill count in a restoring divider that makes one quotient bit per
// cycle. The time from one acceptance to the next is set by the divider,
// plus any time the finished result waits while the output register is
// still full. A finished result waits in the output register while the
// next sample is taken. The threshold register may be written only
// while idle.
module moving_average_anomaly_detector_unit #(
  parameter int WINDOW = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mad_in_if.sink               in_if,
  mad_out_if.source            out_if,
  input  logic                 cfg_we,
  input  mad_pkg::thr_t        cfg_wdata
);
  import mad_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  mad_state_t              state_r, state_nxt;
  logic [IDX_W-1:0]        slot_r, slot_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  thr_t                    thr_r;
  sample_t                 samp_r;
  logic                    out_valid_r;
  sample_t                 out_mean_r;
  logic                    out_anom_r;

  logic                    accept;
  logic                    in_ready;
  logic                    ram_we;
  logic                    div_start;
  logic                    out_load;
  logic                    out_free;
  logic                    full;
  logic [SAMPLE_W-1:0]     old_raw;
  logic                    div_done;
  sample_t                 div_q;
  logic signed [SAMPLE_W:0] dev;
  logic [SAMPLE_W:0]       dev_abs;
  logic                    anom;

  assign accept   = in_if.valid && in_ready;
  assign full     = fill_r == CNT_W'(WINDOW);
  assign out_free = !out_valid_r || out_if.ready;

  mad_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_r),
    .wdata(samp_r),
    .re   (accept),
    .raddr(slot_r),
    .rdata(old_raw)
  );

  mad_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(sum_r),
    .divisor (fill_r),
    .done    (div_done),
    .quotient(div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_if.valid) state_nxt = S_UPD;
      S_UPD:   state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE:  in_ready  = 1'b1;
      S_UPD:   ram_we    = 1'b1;
      S_START: div_start = 1'b1;
      S_FIN:   out_load  = out_free;
      default: ;
    endcase
  end

  // window bookkeeping; the oldest entry leaves the sum only once full
  always_comb begin
    sum_nxt  = sum_r + SUM_W'(samp_r);
    fill_nxt = fill_r + 1'b1;
    if (full) begin
      sum_nxt  = sum_r + SUM_W'(samp_r) - SUM_W'($signed(old_raw));
      fill_nxt = fill_r;
    end
    slot_nxt = (slot_r == IDX_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
  end

  assign dev     = (SAMPLE_W+1)'(samp_r) - (SAMPLE_W+1)'(div_q);
  assign dev_abs = dev[SAMPLE_W] ? $unsigned(-dev) : $unsigned(dev);
  assign anom    = dev_abs > {1'b0, thr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      thr_r       <= THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (ram_we) begin
        slot_r <= slot_nxt;
        fill_r <= fill_nxt;
        sum_r  <= sum_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      samp_r <= in_if.sample;
    end
    if (out_load) begin
      out_mean_r <= div_q;
      out_anom_r <= anom;
    end
  end

  assign in_if.ready    = in_ready;
  assign out_if.valid   = out_valid_r;
  assign out_if.mean    = out_mean_r;
  assign out_if.anomaly = out_anom_r;

  // assertions
  ap_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  ap_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == '0 |-> sum_r == '0)
    else $error("nonzero sum with empty window");

  ap_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside divide state");

  ap_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result loaded outside finish state");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the moving average anomaly detector against an in-bench predictor.
// Each item's mean over the last samples and its anomaly flag are checked.
// A table of directed items opens the run, with the mean near the rails, the
// window wrapping, truncation toward zero and the flag on both sides of the
// threshold. Random phases follow, each at its own threshold and with its
// own idling, and one phase holds the result channel off for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mad_pkg::*;

  localparam int SMA_WINDOW     = 20;
  localparam int RAND_PHASES    = 6;
  localparam int PHASE_ITEMS    = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 60;
  localparam int LIMIT_CYCLES   = 400000;
  localparam int DIR_ROWS       = 22;

  typedef struct packed {
    sample_t mean;
    logic    anomaly;
  } mean_flag_t;

  typedef struct {
    sample_t    smp;
    bit         typed;
    mean_flag_t res;
  } dir_row_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;
  typedef enum int {SEG_SENSOR, SEG_NOISE, SEG_RAIL, SEG_SWING} seg_kind_t;

  logic    clk;
  logic    rst_n;
  logic    cfg_we;
  thr_t    cfg_wdata;

  mad_in_if  in_if ();
  mad_out_if out_if ();

  moving_average_anomaly_detector_unit #(
    .WINDOW (SMA_WINDOW)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  sample_t    window_mem [SMA_WINDOW];
  int         wr_slot;
  int         fill_cnt;
  int         win_sum;
  int         thr_lim;

  mean_flag_t mean_flag_q [$];
  int         err_cnt;
  int         cycle_cnt;

  // idling controls
  rx_mode_t   rx_mode;
  int         rx_tick;
  bit         hold_go;
  int         burst_left;
  int         gap_max;

  // random sample stream
  seg_kind_t  seg_kind;
  int         seg_left;
  int         base_lvl;
  bit         rail_hi;

  // opening rows, expected results typed where they follow at a glance
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{16'sh7FFF,  1'b1, '{16'sh7FFF, 1'b0}},  // single sample at the top rail
    '{16'sh8000,  1'b1, '{16'sd0,    1'b1}},  // -1 / 2 truncates to zero
    '{16'sd1,     1'b1, '{16'sd0,    1'b0}},
    '{16'sd0,     1'b1, '{16'sd0,    1'b0}},
    '{16'sd6400,  1'b1, '{16'sd1280, 1'b0}},  // deviation equal to threshold
    '{16'sd7425,  1'b1, '{16'sd2304, 1'b1}},  // one above threshold
    '{-16'sd13826, 1'b1, '{16'sd0,   1'b1}},  // negative sum truncates up
    '{16'sh7FFF,  1'b0, '0},
    '{16'sh7FFF,  1'b0, '0},
    '{16'sh7FFF,  1'b0, '0},
    '{16'sh8000,  1'b0, '0},
    '{16'sh8000,  1'b0, '0},
    '{16'sh8000,  1'b0, '0},
    '{16'sd256,   1'b0, '0},
    '{-16'sd256,  1'b0, '0},
    '{16'sh5555,  1'b0, '0},
    '{16'shAAAA,  1'b0, '0},
    '{-16'sd1,    1'b0, '0},
    '{16'sd1,     1'b0, '0},
    '{16'sh7FFF,  1'b0, '0},  // window full from here on
    '{16'sh7FFF,  1'b0, '0},
    '{16'sh8000,  1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic mean_flag_t predict(input sample_t s);
    mean_flag_t r;
    int         mean_v;
    int         dev;
    if (fill_cnt < SMA_WINDOW) begin
      fill_cnt++;
    end else begin
      win_sum -= int'(window_mem[wr_slot]);
    end
    window_mem[wr_slot] = s;
    win_sum += int'(s);
    wr_slot = (wr_slot + 1) % SMA_WINDOW;
    mean_v = win_sum / fill_cnt;
    dev = int'(s) - mean_v;
    if (dev < 0) begin
      dev = -dev;
    end
    r.mean    = sample_t'(mean_v);
    r.anomaly = (dev > thr_lim);
    return r;
  endfunction

  function automatic sample_t next_reading();
    int v;
    int pick;
    if (seg_left == 0) begin
      seg_left = $urandom_range(20, 60);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        seg_kind = SEG_SENSOR;
      end else if (pick < 85) begin
        seg_kind = SEG_NOISE;
      end else if (pick < 93) begin
        seg_kind = SEG_RAIL;
      end else begin
        seg_kind = SEG_SWING;
      end
      base_lvl = int'($urandom_range(0, 40000)) - 20000;
      rail_hi  = 1'($urandom_range(0, 1));
    end
    seg_left--;
    case (seg_kind)
      SEG_SENSOR: begin
        base_lvl += int'($urandom_range(0, 64)) - 32;
        v = base_lvl + int'($urandom_range(0, 512)) - 256;
        // occasional spike well off the mean
        if ($urandom_range(0, 15) == 0) begin
          v += ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(2000, 16000));
        end
      end
      SEG_NOISE: v = int'($urandom_range(0, 65535)) - 32768;
      SEG_RAIL:  v = rail_hi ? 32767 : -32768;
      default: begin
        v = rail_hi ? 32767 : -32768;
        rail_hi = !rail_hi;
      end
    endcase
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    return sample_t'(v);
  endfunction

  // called in the time step of a rising edge; returns at the accepting edge or after the idle gap that follows it
  task automatic offer(input sample_t s, input bit typed, input mean_flag_t typed_res);
    mean_flag_t r;
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    do @(negedge clk); while (!in_if.ready);
    @(posedge clk);
    r = predict(s);
    mean_flag_q.push_back(typed ? typed_res : r);
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gap_max > 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (mean_flag_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input thr_t v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    thr_lim    = int'(v);
    burst_left = $urandom_range(1, 40);
  endtask

  // result channel: stall pattern of its own, plus one long hold-off
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (hold_go) begin
        hold_go = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_if.ready <= 1'b0;
          @(posedge clk);
        end
      end
      case (rx_mode)
        RX_ALWAYS:  out_if.ready <= 1'b1;
        RX_RANDOM:  out_if.ready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: out_if.ready <= ((rx_tick % 9) < 5);
        default:    out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // signals are stable between the falling edge and the next rising edge
  initial begin
    mean_flag_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (mean_flag_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing expected: mean %0d anomaly %0b",
                   $realtime, out_if.mean, out_if.anomaly);
        end else begin
          want = mean_flag_q.pop_front();
          if (out_if.mean !== want.mean) begin
            err_cnt++;
            $display("%0t: mean mismatch: expected %0d actual %0d",
                     $realtime, want.mean, out_if.mean);
          end
          if (out_if.anomaly !== want.anomaly) begin
            err_cnt++;
            $display("%0t: anomaly mismatch: expected %0b actual %0b",
                     $realtime, want.anomaly, out_if.anomaly);
          end
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    thr_t thr_plan [RAND_PHASES];
    err_cnt    = 0;
    cycle_cnt  = 0;
    rx_tick    = 0;
    hold_go    = 1'b0;
    rx_mode    = RX_RANDOM;
    gap_max    = 4;
    burst_left = $urandom_range(1, 40);
    seg_left   = 0;
    seg_kind   = SEG_SENSOR;
    base_lvl   = 0;
    rail_hi    = 1'b0;
    wr_slot    = 0;
    fill_cnt   = 0;
    win_sum    = 0;
    thr_lim    = int'(THR_RESET);

    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      offer(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].res);
    end

    thr_plan[0] = '0;
    thr_plan[1] = '1;
    thr_plan[2] = thr_t'($urandom_range(0, 4000));
    thr_plan[3] = 16'd256;
    thr_plan[4] = thr_t'($urandom_range(0, 65535));
    thr_plan[5] = THR_RESET;

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_threshold(thr_plan[p]);
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      case ($urandom_range(0, 2))
        0:       gap_max = 0;
        1:       gap_max = 3;
        default: gap_max = 12;
      endcase
      // back-to-back items against a stopped result channel fill the block
      if (p == 2) begin
        rx_mode = RX_ALWAYS;
        gap_max = 0;
        hold_go = 1'b1;
      end
      repeat (PHASE_ITEMS) offer(next_reading(), 1'b0, '0);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && mean_flag_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ moving_average_anomaly_detector_unit.f @@
rtl/mad_pkg.sv
rtl/mad_in_if.sv
rtl/mad_out_if.sv
rtl/mad_ram.sv
rtl/mad_div.sv
rtl/moving_average_anomaly_detector_unit.sv
tb/testbench.sv
